@@ src/lz_gamma_stream_decompressor_unit_defines.svh @@
// Assertion macros used by the checker file.
`ifndef LZ_GAMMA_STREAM_DECOMPRESSOR_UNIT_DEFINES_SVH
`define LZ_GAMMA_STREAM_DECOMPRESSOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LZG_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("lzg assertion failed");

// Next-cycle implication, disabled during reset.
`define LZG_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("lzg assertion failed");

`endif

@@ src/lzg_pkg.sv @@
`default_nettype none
package lzg_pkg;

  localparam int unsigned HIST_DEPTH_DEFAULT = 65536;

  localparam logic [31:0] OFFSET_BIAS = 32'd767;
  localparam logic [31:0] FAR_OFFSET  = 32'd3328;

  localparam logic [1:0] ST_RUN       = 2'd0;
  localparam logic [1:0] ST_END       = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;
  localparam logic [1:0] ST_BADOFF    = 2'd3;

  typedef enum logic [3:0] {
    PH_TAG, PH_LIT, PH_G1_DATA, PH_G1_STOP, PH_OFFBYTE,
    PH_SL_A, PH_SL_B0, PH_SL_B1, PH_G2_DATA, PH_G2_STOP
  } phase_e;

  typedef enum logic [2:0] {
    CS_IDLE, CS_EXEC, CS_READ, CS_ADV, CS_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic latch_in;
    logic exec;
    logic copy_wr;
    logic adv;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic drain;
    logic copy_nz;
    logic last_copy;
    logic exec_take;
    logic adv_done;
    logic out_full;
  } sts_t;

endpackage
`default_nettype wire

@@ src/lzg_in_if.sv @@
`default_nettype none
interface lzg_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output operation, output data_byte, output final_byte,
                  input ready);
  modport sink (input valid, input operation, input data_byte, input final_byte,
                output ready);
endinterface
`default_nettype wire

@@ src/lzg_out_if.sv @@
`default_nettype none
interface lzg_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       byte_taken;
  logic       copy_pending;
  logic [1:0] run_status;

  modport source (output valid, output out_byte, output out_valid, output byte_taken,
                  output copy_pending, output run_status, input ready);
  modport sink (input valid, input out_byte, input out_valid, input byte_taken,
                input copy_pending, input run_status, output ready);
endinterface
`default_nettype wire

@@ src/lzg_ctrl.sv @@
`default_nettype none
module lzg_ctrl
  import lzg_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      CS_IDLE: begin
        in_ready_o = !sts_i.out_full;
        if (in_valid_i && !sts_i.out_full) begin
          cmd_o.latch_in = 1'b1;
          state_d        = CS_EXEC;
        end
      end
      CS_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.drain) begin
          state_d = sts_i.copy_nz ? CS_READ : CS_DONE;
        end else begin
          state_d = sts_i.exec_take ? CS_ADV : CS_DONE;
        end
      end
      CS_READ: begin
        cmd_o.copy_wr = 1'b1;
        state_d       = sts_i.last_copy ? CS_ADV : CS_DONE;
      end
      CS_ADV: begin
        cmd_o.adv = 1'b1;
        if (sts_i.adv_done) begin
          state_d = CS_DONE;
        end
      end
      CS_DONE: begin
        cmd_o.load_out = 1'b1;
        state_d        = CS_IDLE;
      end
      default: state_d = CS_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ src/lzg_dpath.sv @@
`default_nettype none
module lzg_dpath
  import lzg_pkg::*;
#(
  parameter int unsigned HIST_DEPTH = HIST_DEPTH_DEFAULT
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       operation_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       final_byte_i,
  input  wire cmd_t       cmd_i,
  output sts_t            sts_o,
  input  wire logic       out_ready_i,
  output logic            out_req_o,
  output logic [7:0]      out_byte_o,
  output logic            out_valid_o,
  output logic            byte_taken_o,
  output logic            copy_pending_o,
  output logic [1:0]      run_status_o
);

  localparam int unsigned AW = $clog2(HIST_DEPTH);
  localparam logic [AW:0] DEPTH_X = (AW+1)'(HIST_DEPTH);
  localparam logic [31:0] DEPTH_W = 32'(HIST_DEPTH);

  logic [7:0] hist_mem [HIST_DEPTH];
  logic [7:0] rdata_q;

  logic       op_q, fin_q;
  logic [7:0] data_q;
  logic [31:0] produced_q, produced_d, rep_q, rep_d, gamma_q, gamma_d;
  logic [31:0] dist_q, dist_d, copy_q, copy_d;
  logic [7:0]  tag_q, tag_d;
  logic [3:0]  left_q, left_d;
  phase_e      phase_q, phase_d;
  logic        ended_q, ended_d;
  logic [1:0]  status_q, status_d;
  logic [AW-1:0] wp_q, wp_d;
  logic [7:0]  res_byte_q, res_byte_d;
  logic        res_ov_q, res_ov_d, res_tk_q, res_tk_d;

  logic        ovld_q;
  logic [7:0]  o_byte_q;
  logic        o_ov_q, o_tk_q, o_cp_q;
  logic [1:0]  o_st_q;

  logic        mem_we;
  logic [7:0]  mem_wdata;
  logic [AW:0] wp_ext, d_ext, rp_full;
  logic [AW-1:0] rp;
  logic        exec_take, adv_done;
  logic [3:0]  bit_idx;
  logic        tbit;
  logic [31:0] raw;
  logic        fm_req;
  logic [31:0] fm_len, fm_cnt;
  logic        fm_bad;

  // Copy source address, wrapped into the history window.
  assign wp_ext  = {1'b0, wp_q};
  assign d_ext   = dist_q[AW:0];
  assign rp_full = (wp_ext >= d_ext) ? (wp_ext - d_ext) : (wp_ext + DEPTH_X - d_ext);
  assign rp      = rp_full[AW-1:0];

  assign bit_idx = left_q - 4'd1;
  assign tbit    = tag_q[bit_idx[2:0]];
  assign raw     = (gamma_q << 8) + {24'd0, data_q};

  assign exec_take = !op_q && (status_q == ST_RUN) && (copy_q == 32'd0) && !ended_q &&
                     ((phase_q == PH_LIT) || (phase_q == PH_OFFBYTE) || (left_q == 4'd0));

  always_comb begin
    produced_d = produced_q;
    rep_d      = rep_q;
    gamma_d    = gamma_q;
    dist_d     = dist_q;
    copy_d     = copy_q;
    tag_d      = tag_q;
    left_d     = left_q;
    phase_d    = phase_q;
    ended_d    = ended_q;
    status_d   = status_q;
    wp_d       = wp_q;
    res_byte_d = res_byte_q;
    res_ov_d   = res_ov_q;
    res_tk_d   = res_tk_q;
    mem_we     = 1'b0;
    mem_wdata  = data_q;
    adv_done   = 1'b0;
    fm_req     = 1'b0;
    fm_len     = 32'd0;
    fm_cnt     = 32'd0;
    fm_bad     = 1'b0;

    if (cmd_i.latch_in) begin
      res_byte_d = 8'd0;
      res_ov_d   = 1'b0;
      res_tk_d   = 1'b0;
    end

    if (cmd_i.exec && exec_take) begin
      if (phase_q == PH_LIT) begin
        mem_we     = 1'b1;
        mem_wdata  = data_q;
        res_byte_d = data_q;
        res_ov_d   = 1'b1;
        phase_d    = PH_TAG;
      end else if (phase_q == PH_OFFBYTE) begin
        if (raw == OFFSET_BIAS) begin
          status_d = ST_END;
        end else begin
          dist_d  = raw - OFFSET_BIAS;
          rep_d   = raw - OFFSET_BIAS;
          phase_d = PH_SL_A;
        end
      end else begin
        tag_d  = data_q;
        left_d = 4'd8;
      end
      res_tk_d = 1'b1;
      ended_d  = fin_q;
    end

    if (cmd_i.copy_wr) begin
      mem_we     = 1'b1;
      mem_wdata  = rdata_q;
      res_byte_d = rdata_q;
      res_ov_d   = 1'b1;
      copy_d     = copy_q - 32'd1;
    end

    // One parse step: resolve at most one tag bit.
    if (cmd_i.adv) begin
      if ((status_q != ST_RUN) || (copy_q != 32'd0)) begin
        adv_done = 1'b1;
      end else if ((phase_q == PH_LIT) || (phase_q == PH_OFFBYTE) || (left_q == 4'd0)) begin
        if (ended_q) begin
          status_d = ST_EXHAUSTED;
        end
        adv_done = 1'b1;
      end else begin
        left_d = left_q - 4'd1;
        unique case (phase_q)
          PH_TAG: begin
            if (tbit) begin
              phase_d = PH_LIT;
            end else begin
              gamma_d = 32'd1;
              phase_d = PH_G1_DATA;
            end
          end
          PH_G1_DATA: begin
            gamma_d = {gamma_q[30:0], tbit};
            phase_d = PH_G1_STOP;
          end
          PH_G1_STOP: begin
            if (!tbit) begin
              phase_d = PH_G1_DATA;
            end else if (gamma_q == 32'd2) begin
              dist_d  = rep_q;
              phase_d = PH_SL_A;
            end else begin
              phase_d = PH_OFFBYTE;
            end
          end
          PH_SL_A: phase_d = tbit ? PH_SL_B1 : PH_SL_B0;
          PH_SL_B0, PH_SL_B1: begin
            if ((phase_q == PH_SL_B1) || tbit) begin
              fm_req = 1'b1;
              fm_len = {30'd0, (phase_q == PH_SL_B1), tbit};
            end else begin
              gamma_d = 32'd1;
              phase_d = PH_G2_DATA;
            end
          end
          PH_G2_DATA: begin
            gamma_d = {gamma_q[30:0], tbit};
            phase_d = PH_G2_STOP;
          end
          PH_G2_STOP: begin
            if (!tbit) begin
              phase_d = PH_G2_DATA;
            end else begin
              fm_req = 1'b1;
              fm_len = gamma_q + 32'd2;
            end
          end
          default: phase_d = PH_TAG;
        endcase
      end
    end

    // Close the match: check the offset and set the copy count.
    if (fm_req) begin
      phase_d = PH_TAG;
      fm_cnt  = fm_len + {31'd0, (dist_q > FAR_OFFSET)} + 32'd1;
      fm_bad  = (dist_q == 32'd0) || (dist_q > produced_q) || (dist_q > DEPTH_W);
      if (fm_bad) begin
        status_d = ST_BADOFF;
      end else begin
        copy_d = (fm_cnt == 32'd0) ? 32'hFFFF_FFFF : fm_cnt;
      end
    end

    if (mem_we) begin
      wp_d = (wp_q == AW'(HIST_DEPTH - 1)) ? '0 : wp_q + AW'(1);
      if (produced_q != 32'hFFFF_FFFF) begin
        produced_d = produced_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[wp_q] <= mem_wdata;
    end
    rdata_q <= hist_mem[rp];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      op_q   <= operation_i;
      data_q <= data_byte_i;
      fin_q  <= final_byte_i;
    end
    if (cmd_i.load_out) begin
      o_byte_q <= res_byte_q;
      o_ov_q   <= res_ov_q;
      o_tk_q   <= res_tk_q;
      o_cp_q   <= (copy_q != 32'd0);
      o_st_q   <= status_q;
    end
    res_byte_q <= res_byte_d;
    res_ov_q   <= res_ov_d;
    res_tk_q   <= res_tk_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      produced_q <= 32'd0;
      rep_q      <= 32'd1;
      gamma_q    <= 32'd1;
      dist_q     <= 32'd0;
      copy_q     <= 32'd0;
      tag_q      <= 8'd0;
      left_q     <= 4'd0;
      phase_q    <= PH_TAG;
      ended_q    <= 1'b0;
      status_q   <= ST_RUN;
      wp_q       <= '0;
      ovld_q     <= 1'b0;
    end else begin
      produced_q <= produced_d;
      rep_q      <= rep_d;
      gamma_q    <= gamma_d;
      dist_q     <= dist_d;
      copy_q     <= copy_d;
      tag_q      <= tag_d;
      left_q     <= left_d;
      phase_q    <= phase_d;
      ended_q    <= ended_d;
      status_q   <= status_d;
      wp_q       <= wp_d;
      if (cmd_i.load_out) begin
        ovld_q <= 1'b1;
      end else if (out_ready_i) begin
        ovld_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.drain     = op_q;
    sts_o.copy_nz   = (copy_q != 32'd0);
    sts_o.last_copy = (copy_q == 32'd1);
    sts_o.exec_take = exec_take;
    sts_o.adv_done  = adv_done;
    sts_o.out_full  = ovld_q;
  end

  assign out_req_o      = ovld_q;
  assign out_byte_o     = o_byte_q;
  assign out_valid_o    = o_ov_q;
  assign byte_taken_o   = o_tk_q;
  assign copy_pending_o = o_cp_q;
  assign run_status_o   = o_st_q;

endmodule
`default_nettype wire

@@ src/lz_gamma_stream_decompressor_unit.sv @@
// LZ gamma stream decompressor: takes one request at a time on in_i, either a compressed
// byte (operation 0) or a drain tick (operation 1), and answers every request with exactly
// one result on out_o. A refused byte, or a drain tick with nothing to copy, is executed,
// published, handed over, and then the next request is accepted. An accepted byte is also
// given parse steps after execution, which resolve the tag bits that it lets the parser
// resolve, one bit per cycle. A drain tick that copies goes through the single history
// read port (address, registered read, write-back); the tick ending a copy also runs its
// parse steps. When copy_pending is 1 the host must send drain ticks; offered bytes are then
// refused with byte_taken 0. Once run_status leaves 0 the block stays stopped until reset.
// The history memory holds HIST_DEPTH bytes and needs no clearing after reset.
`default_nettype none
module lz_gamma_stream_decompressor_unit
  import lzg_pkg::*;
#(
  parameter int unsigned HIST_DEPTH = HIST_DEPTH_DEFAULT
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  lzg_in_if.sink   in_i,
  lzg_out_if.source out_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequence each request: accept, execute, optional history read, parse steps, publish.
  lzg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold parser state, history memory and the output register.
  lzg_dpath #(
    .HIST_DEPTH (HIST_DEPTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .operation_i    (in_i.operation),
    .data_byte_i    (in_i.data_byte),
    .final_byte_i   (in_i.final_byte),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (out_o.ready),
    .out_req_o      (out_o.valid),
    .out_byte_o     (out_o.out_byte),
    .out_valid_o    (out_o.out_valid),
    .byte_taken_o   (out_o.byte_taken),
    .copy_pending_o (out_o.copy_pending),
    .run_status_o   (out_o.run_status)
  );

endmodule
`default_nettype wire

@@ src/lzg_checker.sv @@
`default_nettype none
`include "lz_gamma_stream_decompressor_unit_defines.svh"
module lzg_checker
  import lzg_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_req_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_i,
  input wire logic       out_valid_i,
  input wire logic       copy_pending_i,
  input wire logic [1:0] run_status_i
);

  // One request in flight: no accept right after an accept.
  `LZG_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_i, !(in_valid_i && in_ready_i))
  // A result with no decompressed byte carries a zero byte.
  `LZG_ASSERT_IMPL(a_empty_byte_zero, clk_i, rst_ni, out_req_i && !out_valid_i, out_byte_i == 8'd0)
  // A stopped stream never reports a pending copy.
  `LZG_ASSERT_IMPL(a_stop_no_copy, clk_i, rst_ni, out_req_i && (run_status_i != ST_RUN), !copy_pending_i)
  // A stalled result stays offered.
  `LZG_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_req_i && !out_ready_i, out_req_i && $stable(out_byte_i))

endmodule

bind lz_gamma_stream_decompressor_unit lzg_checker u_lzg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_req_i      (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_byte_i     (out_o.out_byte),
  .out_valid_i    (out_o.out_valid),
  .copy_pending_i (out_o.copy_pending),
  .run_status_i   (out_o.run_status)
);
`default_nettype wire
